### rtl/rule_text_syntax_checker_unit_macros.svh
// ---------------------------------------------------------------------------
// rule_text_syntax_checker_unit_macros
// assertion helpers for the rule text syntax checker
// ---------------------------------------------------------------------------
// all of them sample on clk_i and stay quiet while rst_ni is low
`ifndef RULE_TEXT_SYNTAX_CHECKER_UNIT_MACROS_SVH
`define RULE_TEXT_SYNTAX_CHECKER_UNIT_MACROS_SVH

// condition that holds at every edge
`define RTSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define RTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rtsc_pkg.sv
// ---------------------------------------------------------------------------
// rtsc_pkg
// types, character codes and defaults shared by the syntax checker modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtsc_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned OUT_POS_W     = 16;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_A      = 8'h41;

  typedef enum logic [4:0] {
    ST_START      = 5'd0,
    ST_NAME       = 5'd1,
    ST_NAME_ESC   = 5'd2,
    ST_NAME_GAP   = 5'd3,
    ST_TYPE_OPEN  = 5'd4,
    ST_TYPE_ITEM  = 5'd5,
    ST_TYPE_DONE  = 5'd6,
    ST_GROUP_GAP  = 5'd7,
    ST_SYM_OPEN   = 5'd8,
    ST_SYM        = 5'd9,
    ST_SYM_ESC    = 5'd10,
    ST_TGT_GAP    = 5'd11,
    ST_SPECIAL    = 5'd12,
    ST_TGT        = 5'd13,
    ST_TGT_ESC    = 5'd14,
    ST_TGT_END    = 5'd15,
    ST_COMMENT    = 5'd16
  } rtsc_state_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NAME     = 3'd1,
    ERR_TYPE     = 3'd2,
    ERR_BAR      = 3'd3,
    ERR_EMPTY    = 3'd4,
    ERR_SPECIAL  = 3'd5
  } rtsc_err_e;

  typedef struct packed {
    rtsc_state_e next;
    logic        accept;
    rtsc_err_e   err;
  } rtsc_step_t;

endpackage

`default_nettype wire

### rtl/rtsc_fsm.sv
// ---------------------------------------------------------------------------
// rtsc_fsm
// transition function of the recognizer: next state, accept and error kind
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtsc_fsm (
  input  wire logic [7:0]           char_i,
  input  rtsc_pkg::rtsc_state_e     state_i,
  output rtsc_pkg::rtsc_step_t      step_o
);
  import rtsc_pkg::*;

  logic blank;

  assign blank = char_i inside {CH_SPACE, CH_TAB, CH_NL};

  always_comb begin
    step_o.next   = state_i;
    step_o.accept = 1'b0;
    step_o.err    = ERR_NONE;
    case (state_i)
      ST_START: begin
        if (blank) begin
          step_o.next = ST_START; step_o.accept = 1'b1;
        end else if (char_i == CH_DOLLAR) begin
          step_o.next = ST_NAME_ESC;
        end else if (char_i == CH_HASH) begin
          step_o.next = ST_COMMENT; step_o.accept = 1'b1;
        end else begin
          step_o.next = ST_NAME; step_o.accept = 1'b1;
        end
      end
      ST_NAME: begin
        if (char_i == CH_DOLLAR) step_o.next = ST_NAME_ESC;
        else if (blank) step_o.next = ST_NAME_GAP;
        else if (char_i == CH_LPAREN) step_o.next = ST_TYPE_OPEN;
        else begin
          step_o.next = ST_NAME; step_o.accept = 1'b1;
        end
      end
      ST_NAME_ESC: begin
        if (blank) step_o.err = ERR_NAME;
        else begin
          step_o.next = ST_NAME; step_o.accept = 1'b1;
        end
      end
      ST_NAME_GAP: begin
        if (char_i == CH_LPAREN) step_o.next = ST_TYPE_OPEN;
        else if (blank) step_o.next = ST_NAME_GAP;
        else step_o.err = ERR_NAME;
      end
      ST_TYPE_OPEN: begin
        if (blank) step_o.next = ST_TYPE_OPEN;
        else if (char_i inside {CH_S, CH_A}) step_o.next = ST_TYPE_ITEM;
        else if (char_i == CH_RPAREN) begin
          step_o.next = ST_TYPE_DONE; step_o.accept = 1'b1;
        end else step_o.err = ERR_TYPE;
      end
      ST_TYPE_ITEM: begin
        if (char_i == CH_COMMA) step_o.next = ST_TYPE_OPEN;
        else if (blank) step_o.next = ST_TYPE_ITEM;
        else if (char_i == CH_RPAREN) begin
          step_o.next = ST_TYPE_DONE; step_o.accept = 1'b1;
        end else step_o.err = ERR_TYPE;
      end
      ST_TYPE_DONE: begin
        if (blank) begin
          step_o.next = ST_TYPE_DONE; step_o.accept = 1'b1;
        end else if (char_i == CH_BAR) step_o.next = ST_GROUP_GAP;
        else step_o.err = ERR_BAR;
      end
      ST_GROUP_GAP: begin
        if (blank) step_o.next = ST_GROUP_GAP;
        else if (char_i == CH_LPAREN) step_o.next = ST_SYM_OPEN;
        else step_o.err = ERR_BAR;
      end
      ST_SYM_OPEN: begin
        if (char_i == CH_DOLLAR) step_o.next = ST_SYM_ESC;
        else if (char_i == CH_COMMA) begin
          // empty symbol still raises the flag
          step_o.err = ERR_EMPTY; step_o.accept = 1'b1;
        end else if (char_i == CH_AT) begin
          step_o.next = ST_SPECIAL; step_o.accept = 1'b1;
        end else step_o.next = ST_SYM;
      end
      ST_SYM: begin
        if (char_i == CH_COMMA) step_o.next = ST_SYM_OPEN;
        else if (char_i == CH_DOLLAR) step_o.next = ST_SYM_ESC;
        else if (char_i == CH_RPAREN) step_o.next = ST_TGT_GAP;
        else step_o.next = ST_SYM;
      end
      ST_SYM_ESC: step_o.next = ST_SYM;
      ST_TGT_GAP: begin
        if (blank) step_o.next = ST_TGT_GAP;
        else if (char_i == CH_DOLLAR) step_o.next = ST_TGT_ESC;
        else step_o.next = ST_TGT;
      end
      ST_SPECIAL: begin
        if (char_i == CH_LPAREN) step_o.next = ST_TGT_GAP;
        else step_o.err = ERR_SPECIAL;
      end
      ST_TGT: begin
        if (char_i == CH_COMMA) step_o.next = ST_GROUP_GAP;
        else if (char_i == CH_DOLLAR) step_o.next = ST_TGT_ESC;
        else if (blank) step_o.next = ST_TGT_END;
        else if (char_i == CH_SEMI) begin
          step_o.next = ST_START; step_o.accept = 1'b1;
        end else step_o.next = ST_TGT;
      end
      ST_TGT_ESC: begin
        if (blank) step_o.err = ERR_NAME;
        else step_o.next = ST_TGT;
      end
      ST_TGT_END: begin
        if (blank) step_o.next = ST_TGT_END;
        else if (char_i == CH_COMMA) begin
          step_o.next = ST_GROUP_GAP; step_o.accept = 1'b1;
        end else if (char_i == CH_SEMI) begin
          step_o.next = ST_START; step_o.accept = 1'b1;
        end else step_o.err = ERR_NAME;
      end
      ST_COMMENT: begin
        step_o.accept = 1'b1;
        if (char_i == CH_NL) step_o.next = ST_START;
        else step_o.next = ST_COMMENT;
      end
      default: begin
        step_o.next = ST_START;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/rtsc_pos.sv
// ---------------------------------------------------------------------------
// rtsc_pos
// saturating row and column counters, advanced once per processed beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtsc_pos #(
  parameter int unsigned PosWidth = rtsc_pkg::POS_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                restart_i,
  input  wire logic                newline_i,
  output logic [PosWidth-1:0]      row_o,
  output logic [PosWidth-1:0]      col_o
);
  import rtsc_pkg::*;

  logic [PosWidth-1:0] row_q, row_d, col_q, col_d;
  logic [PosWidth-1:0] row_base, col_base;

  assign row_base = restart_i ? '0 : row_q;
  assign col_base = restart_i ? '0 : col_q;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (step_i) begin
      if (newline_i) begin
        row_d = (row_base != '1) ? row_base + 1'b1 : row_base;
        col_d = PosWidth'(1);
      end else begin
        row_d = row_base;
        col_d = (col_base != '1) ? col_base + 1'b1 : col_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_o = row_q;
  assign col_o = col_q;

endmodule

`default_nettype wire

### rtl/rule_text_syntax_checker_unit.sv
// ---------------------------------------------------------------------------
// rule_text_syntax_checker_unit
// Rule text syntax checker.
// Input channel: one byte of rule text per beat (char_code_i) with a
// restart flag (restart_i) that clears state and counters before that byte.
// Output channel: one result beat per input beat, in order: recognizer
// state, sticky error code, accept flag, row and column.
// Throughput: one beat per cycle while the output is not stalled; the transition
// logic between the input register and the result register is a single case over 17 states.
// An accepted byte is captured in the input register, and its result then
// in the result register.
// The recognizer state and the counters live in the result register
// itself, so each beat sees exactly what the previous beat left.
// Reset clears state, error, accept and counters; the first byte after
// reset behaves as after a restart.
// When the receiver stalls, the result holds, the held input byte waits,
// and in_ready_o drops once the input register is full as well.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rule_text_syntax_checker_unit_macros.svh"

module rule_text_syntax_checker_unit #(
  parameter int unsigned POSITION_WIDTH = rtsc_pkg::POS_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    char_code_i,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [4:0]                         parse_state_o,
  output logic [2:0]                         error_code_o,
  output logic                               accept_o,
  output logic [rtsc_pkg::OUT_POS_W-1:0]     row_o,
  output logic [rtsc_pkg::OUT_POS_W-1:0]     column_o
);
  import rtsc_pkg::*;

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        restart_q;
  logic        out_valid_q, out_valid_d;
  logic        advance, proc;

  rtsc_state_e state_q, state_d, state_base;
  rtsc_err_e   err_q, err_d, err_base;
  logic        accept_q, accept_d;
  rtsc_step_t  step;

  logic [POSITION_WIDTH-1:0] row_cnt, col_cnt;

  assign advance    = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q    <= char_code_i;
      restart_q <= restart_i;
    end
  end

  assign state_base = restart_q ? ST_START : state_q;
  assign err_base   = restart_q ? ERR_NONE : err_q;

  rtsc_fsm u_fsm (
    .char_i  (char_q),
    .state_i (state_base),
    .step_o  (step)
  );

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    accept_d    = accept_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
    if (proc) begin
      state_d  = state_base;
      err_d    = err_base;
      accept_d = restart_q ? 1'b0 : accept_q;
      // recognizer freezes once an error is recorded
      if (err_base == ERR_NONE) begin
        accept_d = step.accept;
        if (step.err != ERR_NONE) begin
          err_d = step.err;
        end else begin
          state_d = step.next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      err_q       <= ERR_NONE;
      accept_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      accept_q    <= accept_d;
      out_valid_q <= out_valid_d;
    end
  end

  rtsc_pos #(
    .PosWidth (POSITION_WIDTH)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (proc),
    .restart_i (restart_q),
    .newline_i (char_q == CH_NL),
    .row_o     (row_cnt),
    .col_o     (col_cnt)
  );

  assign out_valid_o   = out_valid_q;
  assign parse_state_o = state_q;
  assign error_code_o  = err_q;
  assign accept_o      = accept_q;
  assign row_o         = OUT_POS_W'(row_cnt);
  assign column_o      = OUT_POS_W'(col_cnt);

  `RTSC_ASSERT_NEXT(a_err_sticky, (err_q != ERR_NONE) && !(proc && restart_q), $stable(err_q) && $stable(state_q), "error code or state left a sticky error")
  `RTSC_ASSERT_NEXT(a_proc_gives_result, proc, out_valid_q, "processed beat produced no result")
  `RTSC_ASSERT_ALWAYS(a_state_range, state_q <= ST_COMMENT, "recognizer state out of range")
  `RTSC_ASSERT_NEXT(a_row_monotonic, proc && !restart_q, row_cnt >= $past(row_cnt), "row count went down without restart")
  `RTSC_ASSERT_NEXT(a_hold_no_proc, !proc, $stable(state_q) && $stable(col_cnt), "state moved without a processed beat")

endmodule

`default_nettype wire

### tb/tb_rule_text_syntax_checker_unit.sv
// ---------------------------------------------------------------------------
// tb_rule_text_syntax_checker_unit
// Streams rule text through the checker one byte per beat. A short table of
// edge cases comes first, then randomly built rules with injected faults.
// Every result beat is checked in order against a typed expectation or a local
// model of the recognizer, under changing amounts of back-pressure on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rule_text_syntax_checker_unit;
  import rtsc_pkg::*;

  typedef struct packed {
    rtsc_state_e st;
    rtsc_err_e   err;
    logic        acc;
    logic [15:0] row;
    logic [15:0] col;
  } scan_report_t;

  typedef struct packed {
    logic [7:0]   ch;
    logic         rs;
    logic         typed;
    scan_report_t want;
  } directed_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       rs;
  } text_beat_t;

  localparam int NUM_DIRECTED = 29;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  char_code_i = 8'h00;
  logic        restart_i   = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [4:0]  parse_state_o;
  logic [2:0]  error_code_o;
  logic        accept_o;
  logic [15:0] row_o;
  logic [15:0] column_o;

  // typed expectation that travels with the beat on the input side
  logic         beat_typed     = 1'b0;
  scan_report_t beat_typed_rep = '0;

  int           send_idle_pct  = 0;
  int           recv_idle_pct  = 0;
  int           mismatch_count = 0;
  scan_report_t scan_view      = '0;
  scan_report_t reports_due[$];
  text_beat_t   rule_beats[$];
  logic         next_restart   = 1'b0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // first byte after reset, no restart
    '{"A",       1'b0, 1'b1, '{ST_NAME, ERR_NONE, 1'b1, 16'd0, 16'd1}},
    '{CH_DOLLAR, 1'b0, 1'b0, '0},
    '{8'hFF,     1'b0, 1'b0, '0},
    '{8'h00,     1'b0, 1'b0, '0},
    '{CH_TAB,    1'b0, 1'b0, '0},
    '{CH_LPAREN, 1'b0, 1'b0, '0},
    '{CH_S,      1'b0, 1'b0, '0},
    '{CH_COMMA,  1'b0, 1'b0, '0},
    '{CH_A,      1'b0, 1'b0, '0},
    '{CH_RPAREN, 1'b0, 1'b0, '0},
    '{CH_NL,     1'b0, 1'b0, '0},
    '{CH_BAR,    1'b0, 1'b0, '0},
    '{CH_LPAREN, 1'b0, 1'b0, '0},
    '{CH_AT,     1'b0, 1'b0, '0},
    '{CH_LPAREN, 1'b0, 1'b0, '0},
    '{CH_DOLLAR, 1'b0, 1'b0, '0},
    '{"x",       1'b0, 1'b0, '0},
    '{CH_SPACE,  1'b0, 1'b0, '0},
    '{CH_COMMA,  1'b0, 1'b0, '0},
    '{CH_LPAREN, 1'b0, 1'b0, '0},
    // empty symbol group: error with accept raised
    '{CH_COMMA,  1'b0, 1'b1, '{ST_SYM_OPEN, ERR_EMPTY, 1'b1, 16'd1, 16'd11}},
    // error holds, counters run on
    '{"q",       1'b0, 1'b1, '{ST_SYM_OPEN, ERR_EMPTY, 1'b1, 16'd1, 16'd12}},
    '{CH_HASH,   1'b1, 1'b1, '{ST_COMMENT, ERR_NONE, 1'b1, 16'd0, 16'd1}},
    '{CH_NL,     1'b0, 1'b1, '{ST_START, ERR_NONE, 1'b1, 16'd1, 16'd1}},
    '{CH_DOLLAR, 1'b1, 1'b0, '0},
    '{CH_SPACE,  1'b0, 1'b1, '{ST_NAME_ESC, ERR_NAME, 1'b0, 16'd0, 16'd2}},
    '{"a",       1'b1, 1'b0, '0},
    '{CH_LPAREN, 1'b0, 1'b0, '0},
    '{"x",       1'b0, 1'b1, '{ST_TYPE_OPEN, ERR_TYPE, 1'b0, 16'd0, 16'd3}}
  };

  rule_text_syntax_checker_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .parse_state_o (parse_state_o),
    .error_code_o  (error_code_o),
    .accept_o      (accept_o),
    .row_o         (row_o),
    .column_o      (column_o)
  );

  always #10 clk_i = ~clk_i;

  // recognizer step plus saturating row and column counters
  function automatic scan_report_t recognize_char(input scan_report_t cur, input logic [7:0] c);
    scan_report_t nxt;
    rtsc_state_e  ns;
    rtsc_err_e    ek;
    logic         acc;
    logic         blank;
    nxt   = cur;
    ns    = cur.st;
    ek    = ERR_NONE;
    acc   = 1'b0;
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    if (c == CH_NL) begin
      if (cur.row != '1) nxt.row = cur.row + 16'd1;
      nxt.col = 16'd1;
    end else if (cur.col != '1) begin
      nxt.col = cur.col + 16'd1;
    end
    if (cur.err == ERR_NONE) begin
      case (cur.st)
        ST_START: begin
          if (blank) begin ns = ST_START; acc = 1'b1; end
          else if (c == CH_DOLLAR) ns = ST_NAME_ESC;
          else if (c == CH_HASH) begin ns = ST_COMMENT; acc = 1'b1; end
          else begin ns = ST_NAME; acc = 1'b1; end
        end
        ST_NAME: begin
          if (c == CH_DOLLAR) ns = ST_NAME_ESC;
          else if (blank) ns = ST_NAME_GAP;
          else if (c == CH_LPAREN) ns = ST_TYPE_OPEN;
          else begin ns = ST_NAME; acc = 1'b1; end
        end
        ST_NAME_ESC: begin
          if (blank) ek = ERR_NAME;
          else begin ns = ST_NAME; acc = 1'b1; end
        end
        ST_NAME_GAP: begin
          if (c == CH_LPAREN) ns = ST_TYPE_OPEN;
          else if (blank) ns = ST_NAME_GAP;
          else ek = ERR_NAME;
        end
        ST_TYPE_OPEN: begin
          if (blank) ns = ST_TYPE_OPEN;
          else if (c == CH_S || c == CH_A) ns = ST_TYPE_ITEM;
          else if (c == CH_RPAREN) begin ns = ST_TYPE_DONE; acc = 1'b1; end
          else ek = ERR_TYPE;
        end
        ST_TYPE_ITEM: begin
          if (c == CH_COMMA) ns = ST_TYPE_OPEN;
          else if (blank) ns = ST_TYPE_ITEM;
          else if (c == CH_RPAREN) begin ns = ST_TYPE_DONE; acc = 1'b1; end
          else ek = ERR_TYPE;
        end
        ST_TYPE_DONE: begin
          if (blank) begin ns = ST_TYPE_DONE; acc = 1'b1; end
          else if (c == CH_BAR) ns = ST_GROUP_GAP;
          else ek = ERR_BAR;
        end
        ST_GROUP_GAP: begin
          if (blank) ns = ST_GROUP_GAP;
          else if (c == CH_LPAREN) ns = ST_SYM_OPEN;
          else ek = ERR_BAR;
        end
        ST_SYM_OPEN: begin
          if (c == CH_DOLLAR) ns = ST_SYM_ESC;
          else if (c == CH_COMMA) begin ek = ERR_EMPTY; acc = 1'b1; end
          else if (c == CH_AT) begin ns = ST_SPECIAL; acc = 1'b1; end
          else ns = ST_SYM;
        end
        ST_SYM: begin
          if (c == CH_COMMA) ns = ST_SYM_OPEN;
          else if (c == CH_DOLLAR) ns = ST_SYM_ESC;
          else if (c == CH_RPAREN) ns = ST_TGT_GAP;
          else ns = ST_SYM;
        end
        ST_SYM_ESC: ns = ST_SYM;
        ST_TGT_GAP: begin
          if (blank) ns = ST_TGT_GAP;
          else if (c == CH_DOLLAR) ns = ST_TGT_ESC;
          else ns = ST_TGT;
        end
        ST_SPECIAL: begin
          if (c == CH_LPAREN) ns = ST_TGT_GAP;
          else ek = ERR_SPECIAL;
        end
        ST_TGT: begin
          if (c == CH_COMMA) ns = ST_GROUP_GAP;
          else if (c == CH_DOLLAR) ns = ST_TGT_ESC;
          else if (blank) ns = ST_TGT_END;
          else if (c == CH_SEMI) begin ns = ST_START; acc = 1'b1; end
          else ns = ST_TGT;
        end
        ST_TGT_ESC: begin
          if (blank) ek = ERR_NAME;
          else ns = ST_TGT;
        end
        ST_TGT_END: begin
          if (blank) ns = ST_TGT_END;
          else if (c == CH_COMMA) begin ns = ST_GROUP_GAP; acc = 1'b1; end
          else if (c == CH_SEMI) begin ns = ST_START; acc = 1'b1; end
          else ek = ERR_NAME;
        end
        ST_COMMENT: begin
          ns  = (c == CH_NL) ? ST_START : ST_COMMENT;
          acc = 1'b1;
        end
        default: begin
          ns  = ST_START;
          acc = 1'b0;
        end
      endcase
      nxt.acc = acc;
      if (ek != ERR_NONE) nxt.err = ek;
      else nxt.st = ns;
    end
    return nxt;
  endfunction

  function automatic logic [7:0] plain_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] solid_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_TAB || b == CH_NL);
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] or_broken(input logic [7:0] good, input int one_in);
    return ($urandom_range(1, one_in) == 1) ? plain_char() : good;
  endfunction

  // queue one byte of a rule, now and then swapped for noise
  task automatic put_char(input logic [7:0] c);
    logic [7:0] b;
    b = c;
    if ($urandom_range(0, 59) == 0) b = 8'($urandom_range(0, 255));
    rule_beats.push_back('{ch: b, rs: next_restart});
    next_restart = 1'b0;
  endtask

  task automatic put_blanks(input int most);
    repeat ($urandom_range(0, most)) put_char(blank_char());
  endtask

  task automatic put_escaped();
    put_char(CH_DOLLAR);
    put_char(($urandom_range(0, 9) == 0) ? blank_char() : solid_char());
  endtask

  task automatic put_word(input int most);
    repeat ($urandom_range(1, most)) begin
      if ($urandom_range(0, 4) == 0) put_escaped();
      else put_char(plain_char());
    end
  endtask

  // one rule: optional comment line, name, type list, bar, transition groups, terminator
  task automatic build_rule();
    int types;
    int groups;
    int syms;
    next_restart = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 4) == 0) begin
      put_char(CH_HASH);
      repeat ($urandom_range(0, 4)) put_char(plain_char());
      put_char(CH_NL);
    end
    put_blanks(1);
    put_word(3);
    put_blanks(2);
    put_char(CH_LPAREN);
    types = $urandom_range(0, 3);
    for (int i = 0; i < types; i++) begin
      if (i > 0) put_char(CH_COMMA);
      put_blanks(1);
      put_char(or_broken(($urandom_range(0, 1) == 1) ? CH_S : CH_A, 12));
      put_blanks(1);
    end
    put_char(CH_RPAREN);
    put_blanks(2);
    put_char(or_broken(CH_BAR, 10));
    put_blanks(2);
    groups = $urandom_range(1, 3);
    for (int g = 0; g < groups; g++) begin
      put_char(CH_LPAREN);
      if ($urandom_range(0, 3) == 0) begin
        put_char(CH_AT);
        put_char(or_broken(CH_LPAREN, 5));
      end else begin
        if ($urandom_range(0, 11) == 0) put_char(CH_COMMA);
        syms = $urandom_range(1, 3);
        for (int k = 0; k < syms; k++) begin
          if (k > 0 && $urandom_range(0, 2) == 0) put_char(CH_COMMA);
          if ($urandom_range(0, 4) == 0) put_escaped();
          else put_char(plain_char());
        end
        put_char(CH_RPAREN);
      end
      put_blanks(2);
      put_word(3);
      put_blanks(1);
      put_char((g == groups - 1) ? CH_SEMI : CH_COMMA);
      put_blanks(1);
    end
  endtask

  // called just after a rising edge; returns at the edge that takes the beat
  task automatic send_text_beat(input logic [7:0] c, input logic rs, input logic typed,
                                input scan_report_t rep);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= c;
    restart_i      <= rs;
    beat_typed     <= typed;
    beat_typed_rep <= rep;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_rules(input int count);
    int         sent;
    text_beat_t b;
    sent = 0;
    while (sent < count) begin
      build_rule();
      while (rule_beats.size() != 0) begin
        b = rule_beats.pop_front();
        send_text_beat(b.ch, b.rs, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (restart_i) scan_view = '0;
      scan_view = recognize_char(scan_view, char_code_i);
      reports_due.push_back(beat_typed ? beat_typed_rep : scan_view);
    end
  end

  always @(posedge clk_i) begin
    scan_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reports_due.size() == 0) begin
        mismatch_count++;
        $display("%0t result beat with nothing outstanding: state %0d err %0d", $time,
                 parse_state_o, error_code_o);
      end else begin
        want = reports_due.pop_front();
        if (parse_state_o !== want.st || error_code_o !== want.err ||
            accept_o !== want.acc || row_o !== want.row || column_o !== want.col) begin
          mismatch_count++;
          $display("%0t mismatch: expected st %0d err %0d acc %0d row %0d col %0d, got st %0d err %0d acc %0d row %0d col %0d",
                   $time, want.st, want.err, want.acc, want.row, want.col,
                   parse_state_o, error_code_o, accept_o, row_o, column_o);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct <= 47;
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_text_beat(directed_rows[i].ch, directed_rows[i].rs, directed_rows[i].typed,
                     directed_rows[i].want);
    send_rules(150);

    send_idle_pct = 47;
    recv_idle_pct <= 19;
    send_rules(150);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    send_rules(150);
    in_valid_i <= 1'b0;

    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && reports_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rtsc_pkg.sv
rtl/rtsc_fsm.sv
rtl/rtsc_pos.sv
rtl/rule_text_syntax_checker_unit.sv
tb/tb_rule_text_syntax_checker_unit.sv
